// ===== hdl/ipd_servo_position_controller_defines.svh =====
// Assertion macros shared by the servo position controller RTL.
// Each macro expands to one labeled concurrent assertion, disabled while reset is low.
`ifndef IPD_SERVO_POSITION_CONTROLLER_DEFINES_SVH
`define IPD_SERVO_POSITION_CONTROLLER_DEFINES_SVH

// Same-cycle implication.
`define IPD_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ipd assertion failed");

// Next-cycle implication.
`define IPD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ipd assertion failed");

`endif

// ===== hdl/ipd_pkg.sv =====
// Types and constants for the servo position controller.
// Used by every module of the block; depends on nothing else.
package ipd_pkg;

    localparam int POS_W      = 10;
    localparam int GAIN_W     = 16;
    localparam int DRIVE_W    = 9;
    localparam int VEL_W      = 11;
    localparam int ERR_W      = 11;
    localparam int PROD_W     = 28;
    localparam int HALF_W     = 16;
    localparam int ACC_W      = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [POS_W-1:0]         POS_MAX   = 10'd1023;
    localparam logic signed [ERR_W-1:0]  DEADBAND  = 11'sd2;
    localparam logic signed [HALF_W-1:0] DRIVE_MAX = 16'sd255;
    localparam logic signed [DRIVE_W-1:0] DRIVE_HI = 9'sd255;
    localparam logic signed [DRIVE_W-1:0] DRIVE_LO = -9'sd255;

    localparam logic [POS_W-1:0]  RST_SEEK_TARGET = 10'd512;
    localparam logic [POS_W-1:0]  RST_SEEK_MIN    = 10'd96;
    localparam logic [POS_W-1:0]  RST_SEEK_MAX    = 10'd928;
    localparam logic [GAIN_W-1:0] RST_KP_GAIN     = 16'd1024;
    localparam logic [GAIN_W-1:0] RST_KV_GAIN     = 16'd768;
    localparam logic [GAIN_W-1:0] RST_KI_GAIN     = 16'd16384;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SEEK_TARGET   = 3'd0,
        REG_SEEK_MIN      = 3'd1,
        REG_SEEK_MAX      = 3'd2,
        REG_REVERSE_SENSE = 3'd3,
        REG_KP_GAIN       = 3'd4,
        REG_KV_GAIN       = 3'd5,
        REG_KI_GAIN       = 3'd6
    } cfg_idx_t;

    typedef struct packed {
        logic [POS_W-1:0]  seek_target;
        logic [POS_W-1:0]  seek_min;
        logic [POS_W-1:0]  seek_max;
        logic              reverse_sense;
        logic [GAIN_W-1:0] kp_gain;
        logic [GAIN_W-1:0] kv_gain;
        logic [GAIN_W-1:0] ki_gain;
    } cfg_t;

    // Captured sample and its velocity.
    typedef struct packed {
        logic [POS_W-1:0]        pos;
        logic signed [VEL_W-1:0] vel;
    } front_t;

    // Products ready for the accumulator stage.
    typedef struct packed {
        logic signed [PROD_W-1:0] prod_i;
        logic signed [HALF_W-1:0] pterm;
        logic signed [HALF_W-1:0] vterm;
        logic [POS_W-1:0]         reported;
    } terms_t;

endpackage

// ===== hdl/ipd_front.sv =====
// Input register stage: captures the sample and forms the velocity.
// Depends on ipd_pkg and the assertion macro header.
`include "ipd_servo_position_controller_defines.svh"

module ipd_front (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [ipd_pkg::POS_W-1:0] sample_position,
    output logic                     front_valid,
    input  logic                     front_ready,
    output ipd_pkg::front_t          front
);
    import ipd_pkg::*;

    logic              s1_valid_reg;
    front_t            s1_reg;
    logic [POS_W-1:0]  last_sample_reg;
    logic              accept;

    assign in_ready    = !s1_valid_reg || front_ready;
    assign accept      = in_valid && in_ready;
    assign front_valid = s1_valid_reg;
    assign front       = s1_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg    <= 1'b0;
            last_sample_reg <= '0;
        end
        else
        begin
            if (in_ready)
            begin
                s1_valid_reg <= in_valid;
            end
            if (accept)
            begin
                last_sample_reg <= sample_position;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_reg.pos <= sample_position;
            s1_reg.vel <= $signed({1'b0, sample_position}) - $signed({1'b0, last_sample_reg});
        end
    end

    `IPD_ASSERT_NEXT(a_front_hold, clk, rst_n, s1_valid_reg && !front_ready, s1_valid_reg && $stable(s1_reg))

endmodule

// ===== hdl/ipd_terms.sv =====
// Error and gain stage: clamps the command, removes the deadband, forms the three products.
// Depends on ipd_pkg.
module ipd_terms (
    input  logic            clk,
    input  logic            rst_n,
    input  ipd_pkg::cfg_t   cfg,
    input  logic            front_valid,
    output logic            front_ready,
    input  ipd_pkg::front_t front,
    output logic            terms_valid,
    input  logic            terms_ready,
    output ipd_pkg::terms_t terms
);
    import ipd_pkg::*;

    logic                     s2_valid_reg;
    terms_t                   s2_reg;
    terms_t                   s2_next;
    logic [POS_W-1:0]         cmd_m;
    logic [POS_W-1:0]         lo_m;
    logic [POS_W-1:0]         hi_m;
    logic [POS_W-1:0]         cmd_lo;
    logic [POS_W-1:0]         cmd;
    logic signed [ERR_W-1:0]  err_raw;
    logic signed [ERR_W-1:0]  err;
    logic [25:0]              pprod;
    logic signed [PROD_W-1:0] vprod;
    logic signed [PROD_W-1:0] vadj;

    assign front_ready = !s2_valid_reg || terms_ready;
    assign terms_valid = s2_valid_reg;
    assign terms       = s2_reg;

    always_comb
    begin
        // Reverse mode mirrors the command and both limits.
        cmd_m = cfg.reverse_sense ? POS_MAX - cfg.seek_target : cfg.seek_target;
        lo_m  = cfg.reverse_sense ? POS_MAX - cfg.seek_min    : cfg.seek_min;
        hi_m  = cfg.reverse_sense ? POS_MAX - cfg.seek_max    : cfg.seek_max;
        // Minimum first, maximum second, so crossed limits resolve to the maximum.
        cmd_lo = (cmd_m < lo_m) ? lo_m : cmd_m;
        cmd    = (cmd_lo > hi_m) ? hi_m : cmd_lo;

        err_raw = $signed({1'b0, cmd}) - $signed({1'b0, front.pos});
        if (err_raw > DEADBAND)
        begin
            err = err_raw - DEADBAND;
        end
        else if (err_raw < -DEADBAND)
        begin
            err = err_raw + DEADBAND;
        end
        else
        begin
            err = '0;
        end

        pprod = front.pos * cfg.kp_gain;
        vprod = front.vel * $signed({1'b0, cfg.kv_gain});
        // Bias negative products so the shift truncates toward zero.
        vadj  = vprod + (vprod[PROD_W-1] ? 28'sd255 : 28'sd0);

        s2_next.prod_i   = err * $signed({1'b0, cfg.ki_gain});
        s2_next.pterm    = pprod[23:8];
        s2_next.vterm    = vadj[23:8];
        s2_next.reported = cfg.reverse_sense ? POS_MAX - front.pos : front.pos;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (front_ready)
        begin
            s2_valid_reg <= front_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (front_valid && front_ready)
        begin
            s2_reg <= s2_next;
        end
    end

endmodule

// ===== hdl/ipd_accum.sv =====
// Accumulator and result stage: integrates, forms the drive, saturates with anti-windup.
// Depends on ipd_pkg and the assertion macro header.
`include "ipd_servo_position_controller_defines.svh"

module ipd_accum (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                terms_valid,
    output logic                                terms_ready,
    input  ipd_pkg::terms_t                     terms,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [ipd_pkg::DRIVE_W-1:0]  drive_value,
    output logic [ipd_pkg::POS_W-1:0]           reported_position
);
    import ipd_pkg::*;

    logic [ACC_W-1:0]          acc_reg;
    logic [ACC_W-1:0]          acc_next;
    logic [ACC_W-1:0]          acc_sum;
    logic signed [HALF_W-1:0]  itg;
    logic signed [HALF_W-1:0]  drive_w;
    logic signed [HALF_W-1:0]  pv;
    logic                      sat_hi;
    logic                      sat_lo;
    logic signed [DRIVE_W-1:0] drive_sat;
    logic                      out_valid_reg;
    logic signed [DRIVE_W-1:0] drive_value_reg;
    logic [POS_W-1:0]          reported_reg;
    logic                      fire;

    assign terms_ready       = !out_valid_reg || out_ready;
    assign fire              = terms_valid && terms_ready;
    assign out_valid         = out_valid_reg;
    assign drive_value       = drive_value_reg;
    assign reported_position = reported_reg;

    always_comb
    begin
        acc_sum = acc_reg + {{(ACC_W-PROD_W){terms.prod_i[PROD_W-1]}}, terms.prod_i};
        itg     = acc_sum[ACC_W-1:HALF_W];
        drive_w = itg - terms.pterm - terms.vterm;
        pv      = terms.pterm + terms.vterm;
        sat_hi  = drive_w > DRIVE_MAX;
        sat_lo  = drive_w < -DRIVE_MAX;
        if (sat_lo)
        begin
            drive_sat = DRIVE_LO;
            acc_next  = {pv - DRIVE_MAX, {HALF_W{1'b0}}};
        end
        else if (sat_hi)
        begin
            drive_sat = DRIVE_HI;
            acc_next  = {pv + DRIVE_MAX, {HALF_W{1'b0}}};
        end
        else
        begin
            drive_sat = drive_w[DRIVE_W-1:0];
            acc_next  = acc_sum;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            acc_reg       <= '0;
        end
        else
        begin
            if (terms_ready)
            begin
                out_valid_reg <= terms_valid;
            end
            if (fire)
            begin
                acc_reg <= acc_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            drive_value_reg <= drive_sat;
            reported_reg    <= terms.reported;
        end
    end

    `IPD_ASSERT_IMPL(a_drive_range, clk, rst_n, out_valid_reg, (drive_value_reg >= DRIVE_LO) && (drive_value_reg <= DRIVE_HI))
    `IPD_ASSERT_NEXT(a_sat_clears_low, clk, rst_n, fire && (sat_hi || sat_lo), acc_reg[HALF_W-1:0] == '0)

endmodule

// ===== hdl/ipd_servo_position_controller.sv =====
// Top level of the servo position controller: configuration registers and the three-stage pipeline.
// Depends on ipd_pkg, ipd_front, ipd_terms, ipd_accum and the assertion macro header.
`include "ipd_servo_position_controller_defines.svh"

// IPD servo position controller with integral anti-windup. Each word on the
// input channel is one 10-bit converter sample; each produces exactly one
// result word carrying a 9-bit signed motor drive (limited to +/-255) and the
// reported position (mirrored in reverse mode). The block takes one word per
// clock cycle while the output is not stalled. Each accepted word passes
// through the input register, where the velocity is formed against the
// previous sample, then the gain stage, where the command is mirrored,
// clamped and compared and the three products are taken, and then the
// accumulator stage, whose add-and-saturate loop on the 32-bit integral
// sets the throughput of one word per cycle. Results wait in the
// output register while the input side keeps filling the pipeline, so stalls
// on the output only stop the input once all three stages hold words.
// Configuration registers are written through the cfg port, which is always
// ready; indexes 0 to 6 follow the register list, other indexes are ignored.
// Writes are meant to happen only while no word is in flight.
module ipd_servo_position_controller (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [ipd_pkg::CFG_IDX_W-1:0]          cfg_index,
    input  logic [ipd_pkg::CFG_DATA_W-1:0]         cfg_data,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic [ipd_pkg::POS_W-1:0]              sample_position,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic signed [ipd_pkg::DRIVE_W-1:0]     drive_value,
    output logic [ipd_pkg::POS_W-1:0]              reported_position
);
    import ipd_pkg::*;

    logic [POS_W-1:0]  seek_target_reg;
    logic [POS_W-1:0]  seek_min_reg;
    logic [POS_W-1:0]  seek_max_reg;
    logic              reverse_sense_reg;
    logic [GAIN_W-1:0] kp_gain_reg;
    logic [GAIN_W-1:0] kv_gain_reg;
    logic [GAIN_W-1:0] ki_gain_reg;
    cfg_t              cfg;
    logic              cfg_write;
    logic              rev_write;

    logic              front_valid;
    logic              front_ready;
    front_t            front;
    logic              terms_valid;
    logic              terms_ready;
    terms_t            terms;

    // The register file never stalls a write.
    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;
    assign rev_write = cfg_write && (cfg_index == REG_REVERSE_SENSE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seek_target_reg   <= RST_SEEK_TARGET;
            seek_min_reg      <= RST_SEEK_MIN;
            seek_max_reg      <= RST_SEEK_MAX;
            reverse_sense_reg <= 1'b0;
            kp_gain_reg       <= RST_KP_GAIN;
            kv_gain_reg       <= RST_KV_GAIN;
            ki_gain_reg       <= RST_KI_GAIN;
        end
        else if (cfg_write)
        begin
            unique case (cfg_idx_t'(cfg_index))
                REG_SEEK_TARGET:   seek_target_reg   <= cfg_data[POS_W-1:0];
                REG_SEEK_MIN:      seek_min_reg      <= cfg_data[POS_W-1:0];
                REG_SEEK_MAX:      seek_max_reg      <= cfg_data[POS_W-1:0];
                REG_REVERSE_SENSE: reverse_sense_reg <= cfg_data[0];
                REG_KP_GAIN:       kp_gain_reg       <= cfg_data[GAIN_W-1:0];
                REG_KV_GAIN:       kv_gain_reg       <= cfg_data[GAIN_W-1:0];
                REG_KI_GAIN:       ki_gain_reg       <= cfg_data[GAIN_W-1:0];
                default:           ;
            endcase
        end
    end

    always_comb
    begin
        cfg.seek_target   = seek_target_reg;
        cfg.seek_min      = seek_min_reg;
        cfg.seek_max      = seek_max_reg;
        cfg.reverse_sense = reverse_sense_reg;
        cfg.kp_gain       = kp_gain_reg;
        cfg.kv_gain       = kv_gain_reg;
        cfg.ki_gain       = ki_gain_reg;
    end

    // Stage one: sample capture and velocity.
    ipd_front u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .sample_position (sample_position),
        .front_valid     (front_valid),
        .front_ready     (front_ready),
        .front           (front)
    );

    // Stage two: command clamp, deadband and products.
    ipd_terms u_terms (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .front_valid (front_valid),
        .front_ready (front_ready),
        .front       (front),
        .terms_valid (terms_valid),
        .terms_ready (terms_ready),
        .terms       (terms)
    );

    // Stage three: integral, drive, saturation and the output register.
    ipd_accum u_accum (
        .clk               (clk),
        .rst_n             (rst_n),
        .terms_valid       (terms_valid),
        .terms_ready       (terms_ready),
        .terms             (terms),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .drive_value       (drive_value),
        .reported_position (reported_position)
    );

    `IPD_ASSERT_NEXT(a_cfg_rev, clk, rst_n, rev_write, reverse_sense_reg == $past(cfg_data[0]))

endmodule
